// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tbf_pkg.sv =====
`default_nettype none

package tbf_pkg;

    localparam int BURST            = 8;
    localparam int WORDS_PER_SAMPLE = 5;
    localparam int WORD_W           = 32;
    localparam int FLAGS_W          = 8;
    localparam int SEQ_W            = 32;
    localparam int SYNC_W           = 32;
    localparam int CFG_W            = 32;
    localparam int ROW_W            = WORDS_PER_SAMPLE * WORD_W;
    localparam int ROW_BYTES        = ROW_W / 8;
    localparam int HDR_BYTES        = 10;
    localparam int CHUNK_BYTES      = 8;
    localparam int CHUNK_W          = CHUNK_BYTES * 8;
    localparam int VB_W             = 4;
    // staging buffer: less than one chunk left over plus one whole row
    localparam int PEND_BYTES       = CHUNK_BYTES - 1 + ROW_BYTES;
    localparam int PEND_W           = PEND_BYTES * 8;
    localparam int CNT_W            = $clog2(PEND_BYTES + 1);
    localparam int BYTE_IDX_W       = $clog2(CHUNK_BYTES);
    localparam int ADDR_W           = (BURST > 1) ? $clog2(BURST) : 1;
    localparam int ROWS_W           = $clog2(BURST + 1);
    localparam logic [7:0] BURST_BYTE = 8'(BURST);

    localparam int CRC_W                = 16;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;
    localparam int CRC_COLS_N           = CRC_W + CHUNK_W;

    typedef enum logic [0:0] {
        REG_ENABLE = 1'b0,
        REG_SYNC   = 1'b1
    } tbf_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_BODY,
        ST_TAIL,
        ST_LAST
    } tbf_state_t;

    typedef struct packed {
        logic               start;
        logic [FLAGS_W-1:0] flags;
    } tbf_start_t;

    typedef logic [CRC_COLS_N-1:0][CRC_W-1:0] tbf_crc_cols_t;

    // one byte, msb first, non-reflected
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if ((c & CRC_TOP) != '0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    // response of an eight-byte step to each single state bit and data bit
    function automatic tbf_crc_cols_t crc_make_cols();
        tbf_crc_cols_t      cols;
        logic [CRC_W-1:0]   c;
        logic [CHUNK_W-1:0] d;
        for (int i = 0; i < CRC_COLS_N; i++) begin
            if (i < CRC_W) begin
                c = CRC_W'(1) << i;
                d = '0;
            end else begin
                c = '0;
                d = CHUNK_W'(1) << (i - CRC_W);
            end
            for (int k = 0; k < CHUNK_BYTES; k++) begin
                c = crc_byte(c, d[8*k +: 8]);
            end
            cols[i] = c;
        end
        return cols;
    endfunction

    localparam tbf_crc_cols_t CRC_COLS = crc_make_cols();

    // eight bytes at once as an xor of independent columns
    function automatic logic [CRC_W-1:0] crc_chunk(input logic [CRC_W-1:0] crc_in,
                                                   input logic [CHUNK_W-1:0] data);
        logic [CRC_W-1:0] r;
        r = '0;
        for (int i = 0; i < CRC_W; i++) begin
            if (crc_in[i]) begin
                r = r ^ CRC_COLS[i];
            end
        end
        for (int j = 0; j < CHUNK_W; j++) begin
            if (data[j]) begin
                r = r ^ CRC_COLS[CRC_W + j];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tbf_if.sv =====
`default_nettype none

interface tbf_sample_if;
    import tbf_pkg::*;

    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  current_a;
    logic [WORD_W-1:0]  current_b;
    logic [WORD_W-1:0]  flux_alpha;
    logic [WORD_W-1:0]  flux_beta;
    logic [WORD_W-1:0]  rotor_speed;
    logic [FLAGS_W-1:0] status_flags;

    modport source (
        output valid, current_a, current_b, flux_alpha, flux_beta, rotor_speed,
               status_flags,
        input  ready
    );

    modport sink (
        input  valid, current_a, current_b, flux_alpha, flux_beta, rotor_speed,
               status_flags,
        output ready
    );
endinterface

interface tbf_chunk_if;
    import tbf_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHUNK_W-1:0] frame_chunk;
    logic [VB_W-1:0]    valid_bytes;
    logic               frame_end;

    modport source (
        output valid, frame_chunk, valid_bytes, frame_end,
        input  ready
    );

    modport sink (
        input  valid, frame_chunk, valid_bytes, frame_end,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/tbf_ram.sv =====
`default_nettype none

module tbf_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/tbf_intake.sv =====
`default_nettype none

module tbf_intake (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    tbf_sample_if.sink                       samples,
    input  wire logic                        enable,
    input  wire logic                        busy,
    output logic                             we,
    output logic [tbf_pkg::ADDR_W-1:0]       waddr,
    output logic [tbf_pkg::ROW_W-1:0]        wdata,
    output tbf_pkg::tbf_start_t              start
);
    import tbf_pkg::*;

    logic [ROWS_W-1:0] fill_reg;
    logic [ROWS_W-1:0] fill_next;
    logic              take;
    logic              last;

    // samples are taken whenever no frame is being built; dropped when disabled
    assign samples.ready = !busy;
    assign take          = samples.valid && samples.ready && enable;
    assign last          = (fill_reg == ROWS_W'(BURST - 1));

    assign we    = take;
    assign waddr = fill_reg[ADDR_W-1:0];
    assign wdata = {samples.rotor_speed, samples.flux_beta, samples.flux_alpha,
                    samples.current_b, samples.current_a};

    assign start.start = take && last;
    assign start.flags = samples.status_flags;

    always_comb
    begin
        fill_next = fill_reg;
        if (take)
        begin
            fill_next = last ? '0 : fill_reg + ROWS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tbf_framer.sv =====
`default_nettype none

module tbf_framer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tbf_pkg::tbf_start_t         start,
    input  wire logic [tbf_pkg::SYNC_W-1:0]  sync_pattern,
    output logic                             busy,
    output logic [tbf_pkg::ADDR_W-1:0]       raddr,
    input  wire logic [tbf_pkg::ROW_W-1:0]   rdata,
    tbf_chunk_if.source                      chunks
);
    import tbf_pkg::*;

    tbf_state_t            state_reg, state_next;
    logic [PEND_W-1:0]     pend_reg, pend_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ROWS_W-1:0]     rows_reg, rows_next;
    logic [CRC_W-1:0]      crc_reg, crc_next;
    logic [BYTE_IDX_W-1:0] tidx_reg, tidx_next;
    logic [SEQ_W-1:0]      seq_reg, seq_next;
    logic [CHUNK_W-1:0]    chunk_reg, chunk_next;
    logic [VB_W-1:0]       vb_reg, vb_next;
    logic                  end_reg, end_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  advance;
    logic                  rows_left;
    logic                  body_take;
    logic                  append;
    logic                  tail_last;
    logic [CNT_W-1:0]      rem;
    logic [PEND_W-1:0]     shifted;

    assign advance   = !out_valid_reg || chunks.ready;
    assign rows_left = (rows_reg != ROWS_W'(BURST));
    assign body_take = (state_reg == ST_BODY) && (cnt_reg >= CNT_W'(CHUNK_BYTES)) && advance;
    assign rem       = body_take ? cnt_reg - CNT_W'(CHUNK_BYTES) : cnt_reg;
    assign shifted   = body_take ? (pend_reg >> CHUNK_W) : pend_reg;
    assign append    = (state_reg == ST_BODY) && rows_left && (rem < CNT_W'(CHUNK_BYTES));
    assign tail_last = ((CNT_W'(tidx_reg) + CNT_W'(1)) == cnt_reg);

    assign busy  = (state_reg != ST_IDLE);
    assign raddr = rows_next[ADDR_W-1:0];

    assign chunks.valid       = out_valid_reg;
    assign chunks.frame_chunk = chunk_reg;
    assign chunks.valid_bytes = vb_reg;
    assign chunks.frame_end   = end_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start.start)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_BODY;
            end
            ST_BODY:
            begin
                if (!rows_left && (cnt_reg < CNT_W'(CHUNK_BYTES)))
                begin
                    state_next = (cnt_reg == '0) ? ST_LAST : ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if (tail_last)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        rows_next      = rows_reg;
        crc_next       = crc_reg;
        tidx_next      = tidx_reg;
        seq_next       = seq_reg;
        chunk_next     = chunk_reg;
        vb_next        = vb_reg;
        end_next       = end_reg;
        out_valid_next = (out_valid_reg && !chunks.ready);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start.start)
                begin
                    // header bytes: sync, sequence, flags, burst count
                    pend_next = PEND_W'({BURST_BYTE, start.flags, seq_reg, sync_pattern});
                    cnt_next  = CNT_W'(HDR_BYTES);
                    rows_next = '0;
                    crc_next  = CRC_INIT;
                    tidx_next = '0;
                    seq_next  = seq_reg + SEQ_W'(1);
                end
            end
            ST_START:
            begin
                // row 0 read is in flight
            end
            ST_BODY:
            begin
                if (body_take)
                begin
                    chunk_next     = pend_reg[CHUNK_W-1:0];
                    vb_next        = VB_W'(CHUNK_BYTES);
                    end_next       = 1'b0;
                    out_valid_next = 1'b1;
                    crc_next       = crc_chunk(crc_reg, pend_reg[CHUNK_W-1:0]);
                end
                if (append)
                begin
                    pend_next = shifted
                              | (PEND_W'(rdata) << {rem[BYTE_IDX_W-1:0], 3'b000});
                    cnt_next  = rem + CNT_W'(ROW_BYTES);
                    rows_next = rows_reg + ROWS_W'(1);
                end
                else
                begin
                    pend_next = shifted;
                    cnt_next  = rem;
                end
            end
            ST_TAIL:
            begin
                crc_next  = crc_byte(crc_reg, pend_reg[{tidx_reg, 3'b000} +: 8]);
                tidx_next = tidx_reg + BYTE_IDX_W'(1);
            end
            ST_LAST:
            begin
                if (advance)
                begin
                    // crc low byte first, right after the last data byte
                    chunk_next     = pend_reg[CHUNK_W-1:0]
                                   | (CHUNK_W'(crc_reg) << {cnt_reg[BYTE_IDX_W-1:0], 3'b000});
                    vb_next        = VB_W'(cnt_reg + CNT_W'(2));
                    end_next       = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rows_reg      <= '0;
            crc_reg       <= CRC_INIT;
            tidx_reg      <= '0;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rows_reg      <= rows_next;
            crc_reg       <= crc_next;
            tidx_reg      <= tidx_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg  <= pend_next;
        chunk_reg <= chunk_next;
        vb_reg    <= vb_next;
        end_reg   <= end_next;
    end

endmodule

`default_nettype wire

// ===== rtl/telemetry_burst_framer_crc16_top.sv =====
// last sample of a burst: framer goes idle, start, body, and body registers the first chunk
// throughput: one sample per cycle while collecting; a frame of 22 chunks is built by a
//   fetch of row 0, one chunk per cycle while the output is ready, and a byte-wise crc
//   over the tail before the final chunk; bursts of 8 samples, intake closed while framing
// reset: asynchronous active low; clears config, fill count, sequence number and handshakes
//   sample memory is not cleared
`default_nettype none

module telemetry_burst_framer_crc16_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire tbf_pkg::tbf_reg_t          wr_index,
    input  wire logic [tbf_pkg::CFG_W-1:0]  wr_data,
    tbf_sample_if.sink                      samples,
    tbf_chunk_if.source                     chunks
);
    import tbf_pkg::*;

    // configuration registers
    logic              enable_reg, enable_next;
    logic [SYNC_W-1:0] sync_reg, sync_next;

    // intake to memory and framer
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ROW_W-1:0]  ram_rdata;
    tbf_start_t        start;
    logic              busy;

    // register file writes; bits above a register's width are dropped
    always_comb
    begin
        enable_next = enable_reg;
        sync_next   = sync_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_ENABLE: enable_next = wr_data[0];
                REG_SYNC:   sync_next   = wr_data[SYNC_W-1:0];
                default:    enable_next = enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            sync_reg   <= '0;
        end
        else
        begin
            enable_reg <= enable_next;
            sync_reg   <= sync_next;
        end
    end

    // sample intake: each sample taken while enabled writes one row of five words;
    // the last row of a burst kicks off the framer, which holds intake off
    tbf_intake u_intake (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .enable  (enable_reg),
        .busy    (busy),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .start   (start)
    );

    // sample store: one row per sample, registered read
    // writes and reads never overlap since intake stalls while a frame is built
    tbf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BURST)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // framer: stages header and rows into a byte buffer, emits eight bytes a cycle unless
    // stalled, folds them into the crc, then appends the crc to the short final chunk
    tbf_framer u_framer (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .sync_pattern (sync_reg),
        .busy         (busy),
        .raddr        (ram_raddr),
        .rdata        (ram_rdata),
        .chunks       (chunks)
    );

endmodule

`default_nettype wire

// ===== rtl/tbf_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module tbf_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [tbf_pkg::CHUNK_W-1:0] out_chunk,
    input wire logic [tbf_pkg::VB_W-1:0]    out_bytes,
    input wire logic                        out_end
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_chunk) && $stable(out_bytes) && $stable(out_end),
        "stalled chunk changed")

    `ASSERT_SAME(a_mid_full, clk, rst_n, out_valid && !out_end, out_bytes == 4'd8,
        "chunk inside a frame is not full")

    `ASSERT_SAME(a_last_range, clk, rst_n, out_valid && out_end,
        out_bytes >= 4'd1 && out_bytes <= 4'd8, "final chunk byte count out of range")

    `ASSERT_SAME(a_no_intake, clk, rst_n, out_valid && !out_end, !in_ready,
        "sample taken while a frame is still being sent")

endmodule

bind telemetry_burst_framer_crc16_top tbf_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (samples.ready),
    .out_valid (chunks.valid),
    .out_ready (chunks.ready),
    .out_chunk (chunks.frame_chunk),
    .out_bytes (chunks.valid_bytes),
    .out_end   (chunks.frame_end)
);

`default_nettype wire
